// ----- design/eca_pkg.sv -----
package eca_pkg;

    // Lattice geometry
    localparam int WIDTH  = 64;
    localparam int HEIGHT = 32;

    // Field widths fixed by the item format
    localparam int OPCODE_W = 2;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 5;
    localparam int RULE_W   = 8;
    localparam int OUT_W    = 64;

    // Width of a column index inside the lattice
    localparam int COLX_W = $clog2(WIDTH);

    // Seed column of the bottom row after reset
    localparam int SEED_COL = WIDTH - 1 - WIDTH / 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd2;

    typedef logic [WIDTH-1:0]  t_row;
    typedef logic [COLX_W-1:0] t_colx;
    typedef logic [RULE_W-1:0] t_rule;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
        logic                cell_in;
    } t_in_item;

    typedef struct packed {
        logic             cell_out;
        logic [OUT_W-1:0] newest_row;
    } t_out_item;

    // Per-transaction control broadcast along the chain of row cells
    typedef struct packed {
        logic  advance;
        logic  write;
        logic  read;
        t_colx column;
        logic  cell_in;
    } t_cell_ctl;

    // Column wrap table: column field reduced modulo WIDTH
    typedef t_colx t_col_table [2**COL_W];

    function automatic t_col_table f_build_col_wrap();
        t_col_table tbl;
        for (int i = 0; i < 2**COL_W; i++) begin
            tbl[i] = t_colx'(i % WIDTH);
        end
        return tbl;
    endfunction

    localparam t_col_table COL_WRAP = f_build_col_wrap();

    localparam t_row SEED_ROW = t_row'(1) << SEED_COL;

endpackage

// ----- design/eca_next_gen.sv -----
module eca_next_gen (
    input  eca_pkg::t_row  i_row,
    input  eca_pkg::t_rule i_rule,
    output eca_pkg::t_row  o_row
);
    import eca_pkg::*;

    // Look up each new cell from its wrapped left, self and right neighbours
    for (genvar i = 0; i < WIDTH; i++) begin : g_lane
        localparam int LCOL = (i == 0) ? WIDTH - 1 : i - 1;
        localparam int RCOL = (i == WIDTH - 1) ? 0 : i + 1;
        logic [2:0] w_pat;
        assign w_pat    = {i_row[LCOL], i_row[i], i_row[RCOL]};
        assign o_row[i] = i_rule[w_pat];
    end

endmodule

// ----- design/eca_row_cell.sv -----
module eca_row_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eca_pkg::t_cell_ctl  i_ctl,
    input  logic                i_row_hit,
    input  eca_pkg::t_row       i_init_row,
    input  eca_pkg::t_row       i_shift_in,
    output eca_pkg::t_row       o_row,
    output eca_pkg::t_row       o_row_next,
    output logic                o_cell
);
    import eca_pkg::*;

    t_row r_row;
    t_row n_row;

    // Take the row from below on advance, or patch one bit on a write hit
    always_comb begin
        n_row = r_row;
        if (i_ctl.advance) begin
            n_row = i_shift_in;
        end else if (i_ctl.write && i_row_hit) begin
            n_row[i_ctl.column] = i_ctl.cell_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= i_init_row;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row      = r_row;
    assign o_row_next = n_row;

    // Drive the selected bit only when this row is read
    assign o_cell = i_ctl.read && i_row_hit && r_row[i_ctl.column];

endmodule

// ----- design/elementary_cellular_automaton.sv -----
// Elementary cellular automaton lattice of HEIGHT rows by WIDTH cells, held as
// a chain of row cells with row 0 at the top. One transaction is taken per
// clock while the output register can take it: the lattice update (advance,
// cell write) lands on the accepting edge and the result sits in the output
// register from the next cycle. The rule lookup across the bottom row and the
// one-bit read select over all rows are combinational. A new transaction is
// accepted whenever the output register is empty or is being drained in the
// same cycle. The lattice takes its seeded state during reset itself; no
// clearing pass follows. The rule register may be rewritten at any idle time
// and is used by every later advance.
module elementary_cellular_automaton (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  eca_pkg::t_rule      i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  eca_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output eca_pkg::t_out_item  o_out_data
);
    import eca_pkg::*;

    t_rule     r_rule_number;
    logic      r_out_valid;
    t_out_item r_out;

    logic      w_accept;
    t_cell_ctl w_ctl;
    t_row      w_next_gen;
    t_row      w_row      [HEIGHT];
    t_row      w_row_next [HEIGHT];
    logic [HEIGHT-1:0] w_cell;

    // Rule register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_number <= '0;
        end else if (i_cfg_we) begin
            r_rule_number <= i_cfg_data;
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Decode the opcode into chain control
    always_comb begin
        w_ctl         = '0;
        w_ctl.column  = COL_WRAP[i_in_data.column];
        w_ctl.cell_in = i_in_data.cell_in;
        unique case (i_in_data.opcode)
            OP_ADVANCE: w_ctl.advance = w_accept;
            OP_READ:    w_ctl.read    = w_accept;
            OP_WRITE:   w_ctl.write   = w_accept;
            default:    ;
        endcase
    end

    eca_next_gen u_next_gen (
        .i_row  (w_row[HEIGHT-1]),
        .i_rule (r_rule_number),
        .o_row  (w_next_gen)
    );

    // Chain of row cells: each takes the row below it on advance
    for (genvar k = 0; k < HEIGHT; k++) begin : g_cell
        localparam t_row INIT_ROW = (k == HEIGHT - 1) ? SEED_ROW : '0;
        logic w_hit;
        t_row w_shift;
        assign w_hit = (int'(i_in_data.row) == k);
        if (k == HEIGHT - 1) begin : g_bottom
            assign w_shift = w_next_gen;
        end else begin : g_upper
            assign w_shift = w_row[k+1];
        end
        eca_row_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_row_hit  (w_hit),
            .i_init_row (INIT_ROW),
            .i_shift_in (w_shift),
            .o_row      (w_row[k]),
            .o_row_next (w_row_next[k]),
            .o_cell     (w_cell[k])
        );
    end

    // Output register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.cell_out   <= |w_cell;
            r_out.newest_row <= OUT_W'(w_row_next[HEIGHT-1]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Held result always matches the bottom row now in the lattice
    a_newest_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.newest_row == OUT_W'(w_row[HEIGHT-1]))
        else $error("held newest_row differs from bottom row");

    // Only a read can report a set cell
    a_cell_only_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.opcode != OP_READ) |=> !r_out.cell_out)
        else $error("cell_out set for a non-read transaction");

    // At most one row cell drives the read bit
    a_one_reader : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cell))
        else $error("several rows answer one read");

    if (HEIGHT > 1) begin : g_scroll_chk
        // Advance moves the old bottom row up by one
        a_scroll : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_ctl.advance |=> w_row[HEIGHT-2] == $past(w_row[HEIGHT-1]))
            else $error("advance did not scroll the bottom row up");
    end

endmodule
